@@ rtl/btpt_pkg.sv @@
// ----------------------------------------------------------------------------
// btpt_pkg
// Shared types and constants of the unibit trie prefix table.
// ----------------------------------------------------------------------------
package btpt_pkg;

  localparam int NODE_COUNT_DEF   = 4096;
  localparam int KEY_BITS_DEF     = 128;
  localparam int PAYLOAD_BITS_DEF = 16;

  localparam int KEY_W  = 128;
  localparam int LEN_W  = 8;
  localparam int DATA_W = 16;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  typedef struct packed {
    logic pop;
    logic push;
  } fl_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fl_stat_t;

endpackage

@@ rtl/btpt_if.sv @@
// ----------------------------------------------------------------------------
// btpt_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface btpt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [63:0] key_high;
  logic [63:0] key_low;
  logic [7:0]  prefix_length;
  logic [15:0] entry_data;

  modport source (output valid, opcode, key_high, key_low, prefix_length, entry_data,
                  input ready);
  modport sink (input valid, opcode, key_high, key_low, prefix_length, entry_data,
                output ready);
endinterface

interface btpt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found;
  logic [15:0] match_data;

  modport source (output valid, status, found, match_data, input ready);
  modport sink (input valid, status, found, match_data, output ready);
endinterface

@@ rtl/binary_trie_prefix_table.sv @@
// ----------------------------------------------------------------------------
// binary_trie_prefix_table
// Longest prefix match table built as a one-bit-per-level trie in a node pool.
// ----------------------------------------------------------------------------
// Request items arrive on in_ch: add or replace, delete, or lookup of a key
// (key_high holds the most significant bits, tested first). Each request
// yields exactly one result item on out_ch: status, found and match_data.
// Requests are handled one at a time. Each trie level takes an address step
// and then a registered node read (S_WALK, S_READ) for lookup and walks over
// existing nodes; a newly created node takes S_WALK, S_ALLOC and S_PLACE.
// in_ch.ready returns in the cycle after the result is loaded. The node pool
// lives in one memory with a single read and a single write port. A finished
// result sits in an output register, so the next request is accepted while
// the receiver stalls; that request then waits for the slot before its own
// result is loaded.
// After reset the table is empty and all nodes are free; no clearing pass is
// needed, since each node is rewritten when it is taken from the pool.
// ----------------------------------------------------------------------------
module binary_trie_prefix_table #(
  parameter int NODE_COUNT   = btpt_pkg::NODE_COUNT_DEF,
  parameter int KEY_BITS     = btpt_pkg::KEY_BITS_DEF,
  parameter int PAYLOAD_BITS = btpt_pkg::PAYLOAD_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  btpt_in_if.sink   in_ch,
  btpt_out_if.source out_ch
);
  import btpt_pkg::*;

  localparam int IW    = $clog2(NODE_COUNT);
  localparam int PW    = $clog2(NODE_COUNT + 1);
  localparam int DW    = $clog2(KEY_BITS + 1);
  localparam int REC_W = 2 * PW + 1 + PAYLOAD_BITS;
  localparam logic [PW-1:0] NO_NODE = PW'(NODE_COUNT);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_WALK  = 6'b000010,
    S_READ  = 6'b000100,
    S_ALLOC = 6'b001000,
    S_PLACE = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state;

  logic [REC_W-1:0] mem [NODE_COUNT];
  logic [REC_W-1:0] rd_data;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [REC_W-1:0] wr_data;

  opcode_t                 op;
  logic [KEY_W-1:0]        key;
  logic [DW-1:0]           len;
  logic [DW-1:0]           depth;
  logic [PAYLOAD_BITS-1:0] data;
  logic [PW-1:0]           root;

  logic                    par_root;
  logic                    side;
  logic [IW-1:0]           par_idx;
  logic [PW-1:0]           par_l;
  logic [PW-1:0]           par_r;
  logic                    par_v;
  logic [PAYLOAD_BITS-1:0] par_p;
  logic [IW-1:0]           cur_idx;
  logic                    new_v;
  logic [PAYLOAD_BITS-1:0] new_p;

  status_t                 res_status;
  logic                    res_found;
  logic [PAYLOAD_BITS-1:0] res_match;

  logic [PW-1:0]           link;
  logic                    at_len;
  logic                    read_done;
  logic [PW-1:0]           rd_l;
  logic [PW-1:0]           rd_r;
  logic                    rd_v;
  logic [PAYLOAD_BITS-1:0] rd_p;

  fl_ctl_t       fl_ctl;
  fl_stat_t      fl_stat;
  logic [IW-1:0] fl_pop_idx;

  btpt_free_list #(.NODE_COUNT(NODE_COUNT)) u_free_list (
    .clk      (clk),
    .rst      (rst),
    .ctl      (fl_ctl),
    .push_idx (cur_idx),
    .stat     (fl_stat),
    .pop_idx  (fl_pop_idx)
  );

  assign link      = par_root ? root : (side ? par_r : par_l);
  assign at_len    = (depth == len);
  assign read_done = (op == OP_LOOKUP) ? (depth == DW'(KEY_BITS)) : at_len;
  assign {rd_l, rd_r, rd_v, rd_p} = rd_data;

  assign fl_ctl.pop  = (state == S_WALK) && (op == OP_ADD) && (link == NO_NODE);
  assign fl_ctl.push = (state == S_READ) && (op == OP_DELETE) && at_len && rd_v &&
                       (rd_l == NO_NODE) && (rd_r == NO_NODE);

  always_ff @(posedge clk) begin
    if (state == S_WALK && link != NO_NODE) begin
      rd_data <= mem[link[IW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_idx;
    wr_data = {rd_l, rd_r, 1'b0, {PAYLOAD_BITS{1'b0}}};
    case (state)
      S_READ: begin
        if (op == OP_ADD && at_len) begin
          wr_en   = 1'b1;
          wr_data = {rd_l, rd_r, 1'b1, data};
        end else if (op == OP_DELETE && at_len && rd_v) begin
          if (rd_l == NO_NODE && rd_r == NO_NODE) begin
            wr_en   = !par_root;
            wr_addr = par_idx;
            wr_data = side ? {par_l, NO_NODE, par_v, par_p} : {NO_NODE, par_r, par_v, par_p};
          end else begin
            wr_en = 1'b1;
          end
        end
      end
      S_ALLOC: begin
        wr_en   = !par_root;
        wr_addr = par_idx;
        wr_data = side ? {par_l, PW'(fl_pop_idx), par_v, par_p}
                       : {PW'(fl_pop_idx), par_r, par_v, par_p};
      end
      S_PLACE: begin
        wr_en   = 1'b1;
        wr_data = {NO_NODE, NO_NODE, new_v, new_p};
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      root         <= NO_NODE;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != S_DONE) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            op         <= opcode_t'(in_ch.opcode);
            key        <= {in_ch.key_high, in_ch.key_low};
            len        <= (in_ch.prefix_length > LEN_W'(KEY_BITS)) ? DW'(KEY_BITS)
                                                                 : DW'(in_ch.prefix_length);
            data       <= PAYLOAD_BITS'(in_ch.entry_data);
            depth      <= '0;
            par_root   <= 1'b1;
            res_status <= ST_OK;
            res_found  <= 1'b0;
            res_match  <= '0;
            state      <= S_WALK;
          end
        end
        S_WALK: begin
          cur_idx <= link[IW-1:0];
          case (op)
            OP_ADD: begin
              if (link != NO_NODE) begin
                state <= S_READ;
              end else if (fl_stat.empty) begin
                res_status <= ST_NO_SPACE;
                state      <= S_DONE;
              end else begin
                state <= S_ALLOC;
              end
            end
            OP_DELETE: begin
              if (link == NO_NODE) begin
                res_status <= ST_NOT_FOUND;
                state      <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end
            OP_LOOKUP: begin
              if (link == NO_NODE) begin
                res_status <= res_found ? ST_OK : ST_NOT_FOUND;
                state      <= S_DONE;
              end else begin
                state <= S_READ;
              end
            end
            default: begin
              res_status <= ST_OK;
              state      <= S_DONE;
            end
          endcase
        end
        S_READ: begin
          par_idx  <= cur_idx;
          par_l    <= rd_l;
          par_r    <= rd_r;
          par_v    <= rd_v;
          par_p    <= rd_p;
          par_root <= 1'b0;
          side     <= key[KEY_W-1];
          key      <= key << 1;
          depth    <= depth + DW'(1);
          state    <= read_done ? S_DONE : S_WALK;
          case (op)
            OP_DELETE: begin
              if (at_len) begin
                res_status <= rd_v ? ST_OK : ST_NOT_FOUND;
                if (rd_v && rd_l == NO_NODE && rd_r == NO_NODE && par_root) begin
                  root <= NO_NODE;
                end
              end
            end
            OP_LOOKUP: begin
              if (rd_v) begin
                res_found <= 1'b1;
                res_match <= rd_p;
              end
              if (depth == DW'(KEY_BITS)) begin
                res_status <= (rd_v || res_found) ? ST_OK : ST_NOT_FOUND;
              end
            end
            default: begin
            end
          endcase
        end
        S_ALLOC: begin
          if (par_root) begin
            root <= PW'(fl_pop_idx);
          end
          cur_idx <= fl_pop_idx;
          new_v   <= at_len;
          new_p   <= at_len ? data : '0;
          state   <= S_PLACE;
        end
        S_PLACE: begin
          if (at_len) begin
            state <= S_DONE;
          end else begin
            par_idx  <= cur_idx;
            par_l    <= NO_NODE;
            par_r    <= NO_NODE;
            par_v    <= new_v;
            par_p    <= new_p;
            par_root <= 1'b0;
            side     <= key[KEY_W-1];
            key      <= key << 1;
            depth    <= depth + DW'(1);
            state    <= S_WALK;
          end
        end
        S_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid      <= 1'b1;
            out_ch.status     <= (op == OP_NONE) ? ST_OK : res_status;
            out_ch.found      <= (op == OP_LOOKUP) && res_found;
            out_ch.match_data <= (op == OP_LOOKUP) ? DATA_W'(res_match) : '0;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_alloc_after_walk: assert property (@(posedge clk) disable iff (rst)
    state == S_ALLOC |-> $past(state) == S_WALK && $past(op) == OP_ADD)
    else $error("node taken outside an add walk");

  a_lookup_status: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.found |-> out_ch.status == ST_OK)
    else $error("match reported with bad status");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    fl_ctl.push |-> !fl_stat.full)
    else $error("node returned to a full pool");

endmodule

@@ rtl/btpt_free_list.sv @@
// ----------------------------------------------------------------------------
// btpt_free_list
// Stack of free node indexes in a memory; untouched slots read as reset order.
// ----------------------------------------------------------------------------
module btpt_free_list #(
  parameter int NODE_COUNT = btpt_pkg::NODE_COUNT_DEF,
  localparam int IW = $clog2(NODE_COUNT),
  localparam int CW = $clog2(NODE_COUNT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  btpt_pkg::fl_ctl_t ctl,
  input  logic [IW-1:0]     push_idx,
  output btpt_pkg::fl_stat_t stat,
  output logic [IW-1:0]     pop_idx
);
  import btpt_pkg::*;

  logic [IW-1:0] mem [NODE_COUNT];
  logic [CW-1:0] count;
  logic [CW-1:0] low_mark;
  logic [CW-1:0] top;
  logic [IW-1:0] rd_data;
  logic [IW-1:0] fresh_val;
  logic          fresh;

  assign top       = count - CW'(1);
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(NODE_COUNT));

  always_ff @(posedge clk) begin
    if (ctl.pop && !stat.empty) begin
      rd_data   <= mem[top[IW-1:0]];
      fresh_val <= IW'(CW'(NODE_COUNT) - count);
    end
    if (ctl.push && !stat.full) begin
      mem[count[IW-1:0]] <= push_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= CW'(NODE_COUNT);
      low_mark <= CW'(NODE_COUNT);
      fresh    <= 1'b0;
    end else if (ctl.pop && !stat.empty) begin
      count <= top;
      fresh <= (count == low_mark);
      if (count == low_mark) begin
        low_mark <= top;
      end
    end else if (ctl.push && !stat.full) begin
      count <= count + CW'(1);
    end
  end

  assign pop_idx = fresh ? fresh_val : rd_data;

endmodule
